/* hw/rtl/dmps_pkg.sv */
`default_nettype none
package dmps_pkg;
  localparam int FRAC_BITS_DEF = 8;
  localparam int ODO_WIDTH_DEF = 32;
  localparam int NREG = 8;
  localparam int PADDR_W = 5;
  localparam int INTEG_LIMIT = 3000;
  localparam int OUT_LIMIT = 7199;
  localparam int DEADZONE = 1800;
  localparam int TRIM_LIMIT = 30;
  localparam int TARGET_LIMIT = 32767;
  localparam int MUL_W = 34;
  localparam int PROD_W = 52;

  localparam logic [1:0] REQ_TICK = 2'd0;
  localparam logic [1:0] REQ_RST_CTRL = 2'd1;
  localparam logic [1:0] REQ_RST_ODO = 2'd2;

  localparam logic [2:0] REG_KP_L = 3'd0;
  localparam logic [2:0] REG_KI_L = 3'd1;
  localparam logic [2:0] REG_KD_L = 3'd2;
  localparam logic [2:0] REG_KP_R = 3'd3;
  localparam logic [2:0] REG_KI_R = 3'd4;
  localparam logic [2:0] REG_KD_R = 3'd5;
  localparam logic [2:0] REG_SYNC = 3'd6;
  localparam logic [2:0] REG_SCALE = 3'd7;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_LOAD,
    OP_PULSE_L,
    OP_PULSE_R,
    OP_SYNC,
    OP_PID_L_PREP,
    OP_PID_L_P,
    OP_PID_L_I,
    OP_PID_L_D,
    OP_PID_L_END,
    OP_PID_R_PREP,
    OP_PID_R_P,
    OP_PID_R_I,
    OP_PID_R_D,
    OP_PID_R_END,
    OP_FINISH
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic [1:0] req;
  } stat_t;
endpackage
`default_nettype wire

/* hw/rtl/dmps_ctrl.sv */
`default_nettype none
module dmps_ctrl (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  wire logic out_stall,
  input  wire dmps_pkg::stat_t stat,
  output dmps_pkg::cmd_t cmd
);
  import dmps_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_OUT} state_t;
  state_t state;
  op_t op;

  assign in_stall = (state != S_IDLE);
  assign cmd.op = (state == S_IDLE && in_valid) ? OP_LOAD : (state == S_RUN ? op : OP_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op <= OP_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_RUN;
            op <= OP_PULSE_L;
          end
        end
        S_RUN: begin
          if (op == OP_FINISH || stat.req != REQ_TICK) begin
            state <= S_OUT;
            out_valid <= 1'b1;
            op <= OP_IDLE;
          end else begin
            op <= op_t'(op + 4'd1);
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            state <= S_IDLE;
            out_valid <= 1'b0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/dmps_dp.sv */
`default_nettype none
module dmps_dp #(
  parameter int FRAC_BITS = dmps_pkg::FRAC_BITS_DEF,
  parameter int ODO_WIDTH = dmps_pkg::ODO_WIDTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire dmps_pkg::cmd_t cmd,
  output dmps_pkg::stat_t stat,
  input  wire logic cfg_we,
  input  wire logic [2:0] cfg_idx,
  input  wire logic [15:0] cfg_data,
  output logic [15:0] cfg_rdata,
  input  wire logic [2:0] cfg_ridx,
  input  wire logic [1:0] req_type,
  input  wire logic signed [15:0] enc_left,
  input  wire logic signed [15:0] enc_right,
  input  wire logic signed [15:0] target_left,
  input  wire logic signed [15:0] target_right,
  output logic signed [13:0] pwm_left,
  output logic signed [13:0] pwm_right,
  output logic [30:0] distance,
  output logic sync_active
);
  import dmps_pkg::*;

  logic [15:0] regs [NREG];
  logic [1:0] req;
  logic signed [15:0] el, er, tl, tr;
  logic signed [ODO_WIDTH-1:0] odo_l, odo_r;
  logic signed [31:0] st_l, st_r;
  logic signed [12:0] integ_l, integ_r;
  logic signed [17:0] lerr_l, lerr_r;
  logic [15:0] ltgt_l, ltgt_r;
  logic signed [13:0] drv_l, drv_r;
  logic signed [16:0] bl, br;
  logic signed [17:0] rl, rr;
  logic signed [17:0] err;
  logic signed [PROD_W-1:0] acc;
  logic sync;

  // shared multiplier
  logic signed [MUL_W-1:0] ma;
  logic [15:0] mb;
  logic signed [PROD_W-1:0] prod;
  assign prod = PROD_W'(ma) * $signed({1'b0, mb});

  function automatic logic signed [ODO_WIDTH-1:0] odo_sat(logic signed [ODO_WIDTH-1:0] a,
                                                           logic signed [15:0] b);
    logic signed [ODO_WIDTH:0] s;
    s = {a[ODO_WIDTH-1], a} + (ODO_WIDTH+1)'(b);
    if (s[ODO_WIDTH] != s[ODO_WIDTH-1])
      return s[ODO_WIDTH] ? {1'b1, {(ODO_WIDTH-1){1'b0}}} : {1'b0, {(ODO_WIDTH-1){1'b1}}};
    return s[ODO_WIDTH-1:0];
  endfunction

  function automatic logic signed [31:0] st_sat(logic signed [31:0] a, logic signed [15:0] b);
    logic signed [32:0] s;
    s = {a[31], a} + 33'(b);
    if (s[32] != s[31]) return s[32] ? 32'sh80000000 : 32'sh7fffffff;
    return s[31:0];
  endfunction

  // truncate toward zero after >> FRAC_BITS
  function automatic logic signed [PROD_W-1:0] tdiv(logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] q;
    q = p >>> FRAC_BITS;
    if (p < 0 && (p & ((PROD_W'(1) << FRAC_BITS) - 1)) != 0) q = q + 1;
    return q;
  endfunction

  logic signed [PROD_W-1:0] pq;
  assign pq = tdiv(prod);

  logic lft;
  logic signed [17:0] cur_tgt;
  logic signed [15:0] cur_enc;
  logic signed [12:0] cur_int;
  assign lft = (cmd.op inside {OP_PID_L_PREP, OP_PID_L_P, OP_PID_L_I, OP_PID_L_D,
                               OP_PID_L_END});
  assign cur_tgt = lft ? rl : rr;
  assign cur_enc = lft ? el : er;
  assign cur_int = lft ? integ_l : integ_r;

  logic signed [18:0] isum;
  logic signed [12:0] isat;
  assign isum = 19'(cur_int) + 19'(cur_tgt - 18'(cur_enc));
  assign isat = (isum > 19'sd3000) ? 13'sd3000 : (isum < -19'sd3000) ? -13'sd3000 : isum[12:0];

  logic signed [PROD_W-1:0] one_v, dz, accf, lim;
  logic signed [13:0] drv_new;
  always_comb begin
    one_v = PROD_W'(1) << FRAC_BITS;
    lim = PROD_W'(OUT_LIMIT) * one_v;
    dz = (cur_tgt > 0) ? PROD_W'(DEADZONE) * one_v : -(PROD_W'(DEADZONE) * one_v);
    accf = acc + dz;
    if (accf > lim) accf = lim;
    else if (accf < -lim) accf = -lim;
    drv_new = 14'(tdiv(accf));
  end

  logic [ODO_WIDTH-1:0] abs_l, abs_r;
  logic [ODO_WIDTH:0] dsum;
  assign abs_l = odo_l[ODO_WIDTH-1] ? ODO_WIDTH'(-odo_l) : odo_l;
  assign abs_r = odo_r[ODO_WIDTH-1] ? ODO_WIDTH'(-odo_r) : odo_r;
  assign dsum = ({1'b0, abs_l} + {1'b0, abs_r}) >> 1;
  always_comb begin
    if (dsum > (ODO_WIDTH+1)'(32'h7fffffff)) distance = 31'h7fffffff;
    else distance = 31'(dsum);
  end

  assign pwm_left = drv_l;
  assign pwm_right = drv_r;
  assign sync_active = sync;
  assign stat.req = req;
  assign cfg_rdata = regs[cfg_ridx];

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (cmd.op)
      OP_PULSE_L: begin ma = MUL_W'(tl); mb = regs[REG_SCALE]; end
      OP_PULSE_R: begin ma = MUL_W'(tr); mb = regs[REG_SCALE]; end
      OP_SYNC: begin ma = MUL_W'(33'(st_l) - 33'(st_r)); mb = regs[REG_SYNC]; end
      OP_PID_L_P: begin ma = MUL_W'(err); mb = regs[REG_KP_L]; end
      OP_PID_L_I: begin ma = MUL_W'(integ_l); mb = regs[REG_KI_L]; end
      OP_PID_L_D: begin ma = MUL_W'(19'(err) - 19'(lerr_l)); mb = regs[REG_KD_L]; end
      OP_PID_R_P: begin ma = MUL_W'(err); mb = regs[REG_KP_R]; end
      OP_PID_R_I: begin ma = MUL_W'(integ_r); mb = regs[REG_KI_R]; end
      OP_PID_R_D: begin ma = MUL_W'(19'(err) - 19'(lerr_r)); mb = regs[REG_KD_R]; end
      default: ;
    endcase
  end

  logic signed [PROD_W-1:0] pclamp, tclamp;
  assign pclamp = (pq > PROD_W'(TARGET_LIMIT)) ? PROD_W'(TARGET_LIMIT) :
                  (pq < -PROD_W'(TARGET_LIMIT)) ? -PROD_W'(TARGET_LIMIT) : pq;
  assign tclamp = (pq > PROD_W'(TRIM_LIMIT)) ? PROD_W'(TRIM_LIMIT) :
                  (pq < -PROD_W'(TRIM_LIMIT)) ? -PROD_W'(TRIM_LIMIT) : pq;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NREG; i++) regs[i] <= (3'(i) == REG_SCALE) ? 16'd280 : 16'd0;
      odo_l <= '0; odo_r <= '0; st_l <= '0; st_r <= '0;
      integ_l <= '0; integ_r <= '0; lerr_l <= '0; lerr_r <= '0;
      ltgt_l <= '0; ltgt_r <= '0; drv_l <= '0; drv_r <= '0;
      sync <= 1'b0; req <= REQ_TICK;
    end else begin
      if (cfg_we) regs[cfg_idx] <= cfg_data;
      unique case (cmd.op)
        OP_LOAD: begin
          req <= req_type; el <= enc_left; er <= enc_right;
          tl <= target_left; tr <= target_right; sync <= 1'b0;
          if (req_type == REQ_TICK) begin
            odo_l <= odo_sat(odo_l, enc_left);
            odo_r <= odo_sat(odo_r, enc_right);
            if (target_left != ltgt_l || target_right != ltgt_r) begin
              ltgt_l <= target_left; ltgt_r <= target_right;
              st_l <= '0; st_r <= '0;
              if (target_left == 0) begin integ_l <= '0; lerr_l <= '0; end
              if (target_right == 0) begin integ_r <= '0; lerr_r <= '0; end
            end
          end else if (req_type == REQ_RST_CTRL) begin
            integ_l <= '0; integ_r <= '0; lerr_l <= '0; lerr_r <= '0;
            st_l <= '0; st_r <= '0; drv_l <= '0; drv_r <= '0;
          end else if (req_type == REQ_RST_ODO) begin
            odo_l <= '0; odo_r <= '0; st_l <= '0; st_r <= '0;
          end
        end
        OP_PULSE_L: bl <= 17'(pclamp);
        OP_PULSE_R: begin
          br <= 17'(pclamp);
          rl <= 18'(bl); rr <= 18'(17'(pclamp));
          if (bl != 0 && pclamp != 0 && tl == tr) begin
            sync <= 1'b1;
            st_l <= st_sat(st_l, el); st_r <= st_sat(st_r, er);
          end else begin
            st_l <= '0; st_r <= '0;
          end
        end
        OP_SYNC: if (sync) begin
          rl <= 18'(bl) - 18'(tclamp);
          rr <= 18'(br) + 18'(tclamp);
        end
        OP_PID_L_PREP, OP_PID_R_PREP: begin
          err <= cur_tgt - 18'(cur_enc);
          acc <= '0;
          if (cur_tgt != 0) begin
            if (lft) integ_l <= isat; else integ_r <= isat;
          end
        end
        OP_PID_L_P, OP_PID_L_I, OP_PID_L_D,
        OP_PID_R_P, OP_PID_R_I, OP_PID_R_D: acc <= acc + prod;
        OP_PID_L_END, OP_PID_R_END: begin
          if (cur_tgt == 0) begin
            if (lft) begin integ_l <= '0; lerr_l <= '0; drv_l <= '0; end
            else begin integ_r <= '0; lerr_r <= '0; drv_r <= '0; end
          end else begin
            if (lft) begin lerr_l <= err; drv_l <= drv_new; end
            else begin lerr_r <= err; drv_r <= drv_new; end
          end
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/dual_motor_pid_speed_sync.sv */
// channel | valid     | stall     | payload
// in      | in_valid  | in_stall  | req_type enc_left enc_right target_left target_right
// out     | out_valid | out_stall | pwm_left pwm_right distance sync_active
// A control tick steps one shared 34x16 multiplier through pulse scaling,
// sync trim and six PID terms.
// One request is in flight at a time.
// rst is synchronous and clears registers to their reset values.
// The result holds while out_stall is high.
`default_nettype none
module dual_motor_pid_speed_sync #(
  parameter int FRAC_BITS = dmps_pkg::FRAC_BITS_DEF,
  parameter int ODO_WIDTH = dmps_pkg::ODO_WIDTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic psel,
  input  wire logic penable,
  input  wire logic pwrite,
  input  wire logic [dmps_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready,
  input  wire logic in_valid,
  output logic in_stall,
  input  wire logic [1:0] req_type,
  input  wire logic signed [15:0] enc_left,
  input  wire logic signed [15:0] enc_right,
  input  wire logic signed [15:0] target_left,
  input  wire logic signed [15:0] target_right,
  output logic out_valid,
  input  wire logic out_stall,
  output logic signed [13:0] pwm_left,
  output logic signed [13:0] pwm_right,
  output logic [30:0] distance,
  output logic sync_active
);
  import dmps_pkg::*;

  cmd_t cmd;
  stat_t stat;
  logic [15:0] rdata;

  assign pready = 1'b1;
  assign prdata = {16'd0, rdata};

  dmps_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .stat, .cmd
  );

  dmps_dp #(.FRAC_BITS(FRAC_BITS), .ODO_WIDTH(ODO_WIDTH)) u_dp (
    .clk, .rst, .cmd, .stat,
    .cfg_we(psel && penable && pwrite && paddr[1:0] == 2'd0),
    .cfg_idx(paddr[4:2]), .cfg_data(pwdata[15:0]),
    .cfg_rdata(rdata), .cfg_ridx(paddr[4:2]),
    .req_type, .enc_left, .enc_right, .target_left, .target_right,
    .pwm_left, .pwm_right, .distance, .sync_active
  );
endmodule
`default_nettype wire

/* hw/rtl/dmps_checker.sv */
`default_nettype none
module dmps_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_stall,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire logic signed [13:0] pwm_left,
  input wire logic signed [13:0] pwm_right
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid) else $error("result dropped");
  a_one_at_time: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("request taken while result pending");
  a_pwm_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pwm_left <= 14'sd7199 && pwm_left >= -14'sd7199 &&
                   pwm_right <= 14'sd7199 && pwm_right >= -14'sd7199))
    else $error("drive out of range");
endmodule

bind dual_motor_pid_speed_sync dmps_checker u_chk (
  .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .pwm_left, .pwm_right
);
`default_nettype wire

/* sim/dual_motor_pid_speed_sync_tb.sv */
`timescale 1ns / 1ps
module dual_motor_pid_speed_sync_tb;
  import dmps_pkg::*;

  typedef struct {
    logic [1:0] req;
    logic signed [15:0] el, er, tl, tr;
  } request_t;

  typedef struct {
    logic signed [13:0] pl, pr;
    logic [30:0] mean_dist;
    logic sync;
  } drive_t;

  logic clk = 0;
  logic rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  wire [31:0] prdata;
  wire pready;
  logic in_valid = 0;
  wire in_stall;
  logic [1:0] req_type = '0;
  logic signed [15:0] enc_left = 0, enc_right = 0, target_left = 0, target_right = 0;
  wire out_valid;
  logic out_stall = 0;
  wire signed [13:0] pwm_left, pwm_right;
  wire [30:0] distance;
  wire sync_active;

  dual_motor_pid_speed_sync i_dut (.*);

  initial forever #5 clk = ~clk;

  request_t pending_reqs[$];
  drive_t expected_drives[$];
  int errors = 0;
  int idle_cycles = 0;
  int hold_off = 0;
  bit long_hold = 0;
  bit send_pause = 0;
  int gap = 0;

  // controller model state
  logic [15:0] gain [8];
  longint odo_l, odo_r, st_l, st_r, int_l, int_r, le_l, le_r, drv_l, drv_r;
  logic [15:0] lt_l, lt_r;

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint to_pulse(longint t);
    return clip((t * longint'(gain[REG_SCALE])) / 256, -TARGET_LIMIT, TARGET_LIMIT);
  endfunction

  function automatic longint run_loop(longint enc, longint tgt, int kp, int ki, int kd,
                                      ref longint integ, ref longint last);
    longint e, acc;
    if (tgt == 0) begin
      integ = 0;
      last = 0;
      return 0;
    end
    e = tgt - enc;
    integ = clip(integ + e, -INTEG_LIMIT, INTEG_LIMIT);
    acc = longint'(gain[kp]) * e + longint'(gain[ki]) * integ
        + longint'(gain[kd]) * (e - last);
    acc += (tgt > 0 ? DEADZONE : -DEADZONE) * 256;
    last = e;
    acc = clip(acc, -OUT_LIMIT * 256, OUT_LIMIT * 256);
    return acc / 256;
  endfunction

  function automatic drive_t control_step(request_t r);
    drive_t d;
    longint bl, br, rl, rr, adj, a, b, mean_dist;
    d.sync = 0;
    if (r.req == REQ_TICK) begin
      odo_l = clip(odo_l + r.el, -(64'sd1 << 31), (64'sd1 << 31) - 1);
      odo_r = clip(odo_r + r.er, -(64'sd1 << 31), (64'sd1 << 31) - 1);
      if (r.tl !== lt_l || r.tr !== lt_r) begin
        lt_l = r.tl;
        lt_r = r.tr;
        st_l = 0;
        st_r = 0;
        if (r.tl == 0) begin int_l = 0; le_l = 0; end
        if (r.tr == 0) begin int_r = 0; le_r = 0; end
      end
      bl = to_pulse(r.tl);
      br = to_pulse(r.tr);
      rl = bl;
      rr = br;
      if (bl != 0 && br != 0 && r.tl == r.tr) begin
        st_l = clip(st_l + r.el, -(64'sd1 << 31), (64'sd1 << 31) - 1);
        st_r = clip(st_r + r.er, -(64'sd1 << 31), (64'sd1 << 31) - 1);
        adj = clip((longint'(gain[REG_SYNC]) * (st_l - st_r)) / 256, -TRIM_LIMIT, TRIM_LIMIT);
        rl = bl - adj;
        rr = br + adj;
        d.sync = 1;
      end else begin
        st_l = 0;
        st_r = 0;
      end
      drv_l = run_loop(r.el, rl, REG_KP_L, REG_KI_L, REG_KD_L, int_l, le_l);
      drv_r = run_loop(r.er, rr, REG_KP_R, REG_KI_R, REG_KD_R, int_r, le_r);
    end else if (r.req == REQ_RST_CTRL) begin
      int_l = 0; int_r = 0; le_l = 0; le_r = 0;
      st_l = 0; st_r = 0; drv_l = 0; drv_r = 0;
    end else if (r.req == REQ_RST_ODO) begin
      odo_l = 0; odo_r = 0; st_l = 0; st_r = 0;
    end
    a = odo_l < 0 ? -odo_l : odo_l;
    b = odo_r < 0 ? -odo_r : odo_r;
    mean_dist = (a + b) / 2;
    if (mean_dist > 64'h7FFFFFFF) mean_dist = 64'h7FFFFFFF;
    d.pl = drv_l[13:0];
    d.pr = drv_r[13:0];
    d.mean_dist = mean_dist[30:0];
    return d;
  endfunction

  function automatic int short_or_long_gap();
    int p = $urandom_range(0, 99);
    if (p < 40) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // sender
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) expected_drives.push_back(control_step(pending_reqs.pop_front()));
      if (gap > 0) begin
        gap <= gap - 1;
        in_valid <= 0;
      end else if (!send_pause && pending_reqs.size() > 0) begin
        in_valid <= 1;
        req_type <= pending_reqs[0].req;
        enc_left <= pending_reqs[0].el;
        enc_right <= pending_reqs[0].er;
        target_left <= pending_reqs[0].tl;
        target_right <= pending_reqs[0].tr;
        gap <= short_or_long_gap();
      end else begin
        in_valid <= 0;
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    drive_t x;
    int g;
    if (rst) begin
      out_stall <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_drives.size() == 0) begin
          $display("%0t: result with no request waiting: %0d %0d %0d %0d", $time,
                   pwm_left, pwm_right, distance, sync_active);
          errors++;
        end else begin
          x = expected_drives.pop_front();
          if (pwm_left !== x.pl)
            begin $display("%0t: pwm_left exp %0d got %0d", $time, x.pl, pwm_left); errors++; end
          if (pwm_right !== x.pr)
            begin $display("%0t: pwm_right exp %0d got %0d", $time, x.pr, pwm_right); errors++; end
          if (distance !== x.mean_dist)
            begin
              $display("%0t: distance exp %0d got %0d", $time, x.mean_dist, distance);
              errors++;
            end
          if (sync_active !== x.sync)
            begin $display("%0t: sync_active exp %0d got %0d", $time, x.sync, sync_active); errors++; end
        end
      end
      if (long_hold) begin
        hold_off <= 300;
        out_stall <= 1;
      end else if (hold_off > 1) begin
        hold_off <= hold_off - 1;
        out_stall <= 1;
      end else begin
        g = ($urandom_range(0, 2) == 0) ? short_or_long_gap() : 0;
        hold_off <= g;
        out_stall <= (g > 0);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [15:0] v);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= {16'd0, v};
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    gain[idx] = v;
  endtask

  task automatic drain();
    wait (pending_reqs.size() == 0 && !in_valid);
    wait (expected_drives.size() == 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic add_req(logic [1:0] k, logic [15:0] el, logic [15:0] er,
                         logic [15:0] tl, logic [15:0] tr);
    request_t r;
    r.req = k; r.el = el; r.er = er; r.tl = tl; r.tr = tr;
    pending_reqs.push_back(r);
  endtask

  task automatic random_phase(int n);
    logic [15:0] t, e;
    for (int i = 0; i < n; i++) begin
      int p = $urandom_range(0, 99);
      if (p < 4)
        add_req(REQ_RST_CTRL, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      else if (p < 7)
        add_req(REQ_RST_ODO, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      else if (p < 9)
        add_req(2'd3, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      else if (p < 15)
        add_req(REQ_TICK, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      else begin
        if ($urandom_range(0, 9) == 0)
          t = 16'($urandom_range(0, 1) ? $urandom : -$urandom_range(0, 2000));
        else if (i == 0 || $urandom_range(0, 7) == 0)
          t = 16'($urandom_range(0, 1) ? $urandom_range(0, 600) : -$urandom_range(0, 600));
        else t = pending_reqs[$].tl;
        e = 16'($signed(t) / 2 + $signed(16'($urandom_range(0, 40))) - 20);
        if ($urandom_range(0, 3) == 0)
          add_req(REQ_TICK, e, 16'(e + $urandom_range(0, 8) - 4), t,
                  16'(t + $urandom_range(0, 1)));
        else
          add_req(REQ_TICK, e, 16'(e + $urandom_range(0, 8) - 4), t, t);
      end
    end
  endtask

  initial begin
    logic [15:0] v;
    for (int i = 0; i < 8; i++) gain[i] = 0;
    gain[REG_SCALE] = 280;
    odo_l = 0; odo_r = 0; st_l = 0; st_r = 0; int_l = 0; int_r = 0;
    le_l = 0; le_r = 0; drv_l = 0; drv_r = 0; lt_l = 0; lt_r = 0;
    repeat (2) @(posedge clk);
    rst <= 0;

    write_reg(REG_KP_L, 16'd512);
    write_reg(REG_KI_L, 16'd64);
    write_reg(REG_KD_L, 16'd128);
    write_reg(REG_KP_R, 16'd512);
    write_reg(REG_KI_R, 16'd64);
    write_reg(REG_KD_R, 16'd128);
    write_reg(REG_SYNC, 16'd256);
    write_reg(REG_SCALE, 16'd280);

    add_req(REQ_TICK, 0, 0, 0, 0);
    add_req(REQ_TICK, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000);
    add_req(REQ_TICK, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF);
    add_req(REQ_TICK, 100, 90, 256, 256);
    add_req(REQ_TICK, 120, 80, 256, 256);
    add_req(REQ_TICK, 32767, -32768, 256, 256);
    add_req(REQ_TICK, -5, 5, -256, -256);
    add_req(REQ_TICK, 0, 0, 1, 1);
    add_req(REQ_TICK, 10, 10, 256, 0);
    add_req(REQ_TICK, 10, 10, 0, 256);
    add_req(REQ_RST_CTRL, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    add_req(REQ_TICK, 300, 300, 512, 512);
    add_req(REQ_RST_ODO, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    add_req(2'd3, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
    for (int i = 0; i < 6; i++) add_req(REQ_TICK, 16'sh7FFF, 16'sh7FFF, 100, 100);
    for (int i = 0; i < 4; i++) add_req(REQ_TICK, 16'sh8000, 16'sh8000, -100, -100);
    drain();

    for (int ph = 0; ph < 7; ph++) begin
      if (ph == 0) v = 16'hFFFF;
      else if (ph == 1) v = 0;
      else v = 16'($urandom_range(0, 1200));
      for (int r = 0; r < 6; r++) write_reg(r[2:0], ph < 2 ? v : 16'($urandom_range(0, 1200)));
      write_reg(REG_SYNC, ph == 0 ? 16'hFFFF : ph == 1 ? 16'd0 : 16'($urandom_range(0, 2000)));
      write_reg(REG_SCALE, ph == 0 ? 16'hFFFF : ph == 1 ? 16'd0 : ph == 2 ? 16'd1
                                              : 16'($urandom_range(100, 600)));
      random_phase(100);
      if (ph == 3) begin
        repeat (5) @(posedge clk);
        long_hold <= 1;
        @(posedge clk);
        long_hold <= 0;
      end
      if (ph == 4) begin
        send_pause <= 1;
        wait (expected_drives.size() == 0 && !in_valid);
        repeat (30) @(posedge clk);
        send_pause <= 0;
      end
      drain();
    end

    if (errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end
endmodule

/* files.f */
hw/rtl/dmps_pkg.sv
hw/rtl/dmps_ctrl.sv
hw/rtl/dmps_dp.sv
hw/rtl/dual_motor_pid_speed_sync.sv
hw/rtl/dmps_checker.sv
sim/dual_motor_pid_speed_sync_tb.sv
